### rtl/multi_source_progress_watchdog_core_assert.svh
// ----------------------------------------------------------------------------
// Progress watchdog assertion macros
// Concurrent assertion wrappers; they compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef MULTI_SOURCE_PROGRESS_WATCHDOG_CORE_ASSERT_SVH
`define MULTI_SOURCE_PROGRESS_WATCHDOG_CORE_ASSERT_SVH

`ifndef SYNTH

// Checked on aclk, skipped while aresetn is low
`define MSW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checked on aclk at every edge, reset included
`define MSW_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`else

`define MSW_ASSERT(lbl, prop, msg)
`define MSW_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

### rtl/msw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msw_pkg
// Shared types and constants of the progress watchdog supervisor.
// ----------------------------------------------------------------------------
package msw_pkg;

    localparam int SRC_IDX_W  = 5;
    localparam int TIME_W     = 32;
    localparam int TIMEOUT_W  = 16;
    localparam int PERIOD_W   = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [PERIOD_W-1:0]  CHECK_PERIOD_RESET     = 8'd10;
    localparam logic [TIMEOUT_W-1:0] PROGRESS_TIMEOUT_RESET = 16'd30;

    typedef enum logic [1:0] {
        REQ_HEARTBEAT  = 2'd0,
        REQ_TICK       = 2'd1,
        REQ_CHECKPOINT = 2'd2,
        REQ_EARLY      = 2'd3
    } req_type_t;

    typedef enum logic {
        CFG_CHECK_PERIOD     = 1'b0,
        CFG_PROGRESS_TIMEOUT = 1'b1
    } cfg_index_t;

    // Controls from the request stage to the source bank
    typedef struct packed {
        logic                 mark;
        logic [SRC_IDX_W-1:0] mark_index;
        logic                 check;
        logic [TIME_W-1:0]    now;
        logic [TIMEOUT_W-1:0] timeout;
    } bank_ctrl_t;

endpackage

`default_nettype wire

### rtl/multi_source_progress_watchdog_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_source_progress_watchdog_core
// Supervisor of task heartbeats and the sampling interrupt that drives the
// watchdog refresh and latches failure on lost progress.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ channel: heartbeat (with source index), millisecond
//   tick, flash checkpoint request and early refresh request. Every request
//   yields exactly one result on the m_ channel with the kick flag, failure
//   latch, checkpoint permission, last check result and a bad-index flag.
//   A request is held in the input register and is evaluated in one pass
//   into the output register, which drives m_tvalid. One request per cycle
//   is sustained while m_tready stays high; the single pass of the source
//   bank's parallel age compares over all NUM_TASKS+1 sources sets that rate.
//   When m_tready is low, the result holds in the output register, the input
//   register still takes one more request, and s_tready drops after that.
//   Reset (aresetn low, synchronous) clears all sources, the clock, the
//   failure latch and loads check_period 10 and progress_timeout 30.
//   Write the cfg port only while no request is in flight.
// ----------------------------------------------------------------------------
`include "multi_source_progress_watchdog_core_assert.svh"

module multi_source_progress_watchdog_core
    import msw_pkg::*;
#(
    parameter int NUM_TASKS = 4
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Configuration write port
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // Request channel
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,  // [1:0] req_type, [6:2] source_index
    // Result channel
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [7:0]                 m_tdata   // [0] refresh_kick, [1] failed,
                                                 // [2] checkpoint_allowed, [3] healthy,
                                                 // [4] bad_source
);

    localparam int SRC_COUNT = NUM_TASKS + 1;

    // Configuration
    logic [PERIOD_W-1:0]  check_period_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;

    // Input register
    logic                 in_valid_reg;
    req_type_t            in_req_reg;
    logic [SRC_IDX_W-1:0] in_src_reg;

    // Supervisor state
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic                allow_reg, allow_next;
    logic                fail_reg, fail_next;
    logic                early_reg, early_next;
    logic                healthy_reg, healthy_next;

    // Output register
    logic out_valid_reg;
    logic out_kick_reg, out_failed_reg, out_allow_reg, out_healthy_reg, out_bad_reg;

    logic                fire;
    logic                kick;
    logic                bad;
    logic [PERIOD_W-1:0] period_inc;
    logic [TIME_W-1:0]   now_inc;
    logic                run_check;
    logic                check_ok;
    bank_ctrl_t          bank_ctrl;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    assign period_inc = period_reg + 1'b1;
    assign now_inc    = now_reg + 1'b1;

    always_comb begin
        now_next     = now_reg;
        period_next  = period_reg;
        allow_next   = allow_reg;
        fail_next    = fail_reg;
        early_next   = early_reg;
        healthy_next = healthy_reg;
        kick         = 1'b0;
        bad          = 1'b0;
        run_check    = 1'b0;
        case (in_req_reg)
            REQ_HEARTBEAT: begin
                bad = (in_src_reg > SRC_IDX_W'(NUM_TASKS));
            end
            REQ_TICK: begin
                now_next = now_inc;
                if (period_inc >= check_period_reg) begin
                    period_next = '0;
                    run_check   = !fail_reg;
                end else begin
                    period_next = period_inc;
                end
                if (run_check) begin
                    healthy_next = check_ok;
                    if (check_ok) begin
                        allow_next = 1'b1;
                        kick       = 1'b1;
                    end else if (now_inc >= {{(TIME_W-TIMEOUT_W){1'b0}}, timeout_reg}) begin
                        allow_next = 1'b0;
                        fail_next  = 1'b1;
                    end
                end
            end
            REQ_CHECKPOINT: begin
                kick = allow_reg && !fail_reg;
            end
            REQ_EARLY: begin
                if (!early_reg && !fail_reg) begin
                    early_next = 1'b1;
                    kick       = 1'b1;
                end
            end
            default: begin
                kick = 1'b0;
            end
        endcase
    end

    always_comb begin
        bank_ctrl.mark       = fire && (in_req_reg == REQ_HEARTBEAT) && !bad;
        bank_ctrl.mark_index = in_src_reg;
        bank_ctrl.check      = fire && run_check;
        bank_ctrl.now        = now_inc;
        bank_ctrl.timeout    = timeout_reg;
    end

    msw_source_bank #(
        .SRC_COUNT (SRC_COUNT)
    ) u_source_bank (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (bank_ctrl),
        .check_ok (check_ok)
    );

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            check_period_reg <= CHECK_PERIOD_RESET;
            timeout_reg      <= PROGRESS_TIMEOUT_RESET;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_addr))
                CFG_CHECK_PERIOD:     check_period_reg <= cfg_wdata[PERIOD_W-1:0];
                CFG_PROGRESS_TIMEOUT: timeout_reg      <= cfg_wdata[TIMEOUT_W-1:0];
                default:              timeout_reg      <= timeout_reg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_req_reg <= req_type_t'(s_tdata[1:0]);
            in_src_reg <= s_tdata[6:2];
        end
    end

    // Supervisor state advances only on a processed request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg     <= '0;
            period_reg  <= '0;
            allow_reg   <= 1'b0;
            fail_reg    <= 1'b0;
            early_reg   <= 1'b0;
            healthy_reg <= 1'b0;
        end else if (fire) begin
            now_reg     <= now_next;
            period_reg  <= period_next;
            allow_reg   <= allow_next;
            fail_reg    <= fail_next;
            early_reg   <= early_next;
            healthy_reg <= healthy_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_kick_reg    <= kick;
            out_failed_reg  <= fail_next;
            out_allow_reg   <= allow_next;
            out_healthy_reg <= healthy_next;
            out_bad_reg     <= bad;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_bad_reg, out_healthy_reg, out_allow_reg,
                       out_failed_reg, out_kick_reg};

    `MSW_ASSERT(a_fail_latched, fail_reg |=> fail_reg, "failure latch released")
    `MSW_ASSERT(a_allow_not_failed, !(allow_reg && fail_reg),
                "checkpoints allowed after failure")
    `MSW_ASSERT(a_no_kick_when_failed, (out_valid_reg && out_failed_reg) |-> !out_kick_reg,
                "watchdog kicked after failure")
    `MSW_ASSERT(a_fail_on_request, $rose(fail_reg) |-> $past(fire),
                "failure set without a processed request")

endmodule

`default_nettype wire

### rtl/msw_source_bank.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msw_source_bank
// Per-source pending, seen and last-progress registers with parallel age check.
// ----------------------------------------------------------------------------
`include "multi_source_progress_watchdog_core_assert.svh"

module msw_source_bank
    import msw_pkg::*;
#(
    parameter int SRC_COUNT = 5
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire bank_ctrl_t ctrl,
    output logic            check_ok
);

    logic [SRC_COUNT-1:0] pending_reg, pending_next;
    logic [SRC_COUNT-1:0] seen_reg, seen_next;
    logic [TIME_W-1:0]    lpt_reg [SRC_COUNT];
    logic [SRC_COUNT-1:0] stale;

    always_comb begin
        pending_next = pending_reg;
        seen_next    = seen_reg;
        for (int s = 0; s < SRC_COUNT; s++) begin
            if (ctrl.mark && ctrl.mark_index == SRC_IDX_W'(s)) begin
                pending_next[s] = 1'b1;
            end
        end
        if (ctrl.check) begin
            seen_next    = seen_reg | pending_reg;
            pending_next = '0;
        end
    end

    // A pending source gets the current time, so its age is zero
    always_comb begin
        for (int s = 0; s < SRC_COUNT; s++) begin
            if (pending_reg[s]) begin
                stale[s] = (ctrl.timeout == '0);
            end else begin
                stale[s] = (TIME_W'(ctrl.now - lpt_reg[s])
                            >= {{(TIME_W-TIMEOUT_W){1'b0}}, ctrl.timeout});
            end
        end
        check_ok = (&(seen_reg | pending_reg)) && !(|stale);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            seen_reg    <= '0;
        end else begin
            pending_reg <= pending_next;
            seen_reg    <= seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < SRC_COUNT; s++) begin
                lpt_reg[s] <= '0;
            end
        end else begin
            for (int s = 0; s < SRC_COUNT; s++) begin
                if (ctrl.check && pending_reg[s]) begin
                    lpt_reg[s] <= ctrl.now;
                end
            end
        end
    end

    `MSW_ASSERT(a_check_clears_pending, ctrl.check |=> (pending_reg == '0),
                "pending sources not cleared by health check")
    `MSW_ASSERT(a_seen_sticky,
                (seen_reg != '0) |=> ((seen_reg & $past(seen_reg)) == $past(seen_reg)),
                "seen bit dropped")

endmodule

`default_nettype wire

### test/tb_multi_source_progress_watchdog_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_source_progress_watchdog_core
// Streams heartbeat, tick, checkpoint and early refresh requests into the
// progress watchdog, mirrors the supervisor state in a local model and checks
// every result byte in order. Phases step through several check periods and
// timeouts, and the last one forces the failure latch.
// ----------------------------------------------------------------------------
module tb_multi_source_progress_watchdog_core;
    import msw_pkg::*;

    localparam int NUM_TASKS  = 4;
    localparam int SRC_COUNT  = NUM_TASKS + 1;
    localparam int CYCLE_CAP  = 200000;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic                  cfg_addr  = CFG_CHECK_PERIOD;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;

    multi_source_progress_watchdog_core #(
        .NUM_TASKS(NUM_TASKS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Supervisor mirror
    logic [7:0]           period_reg  = CHECK_PERIOD_RESET;
    logic [15:0]          timeout_reg = PROGRESS_TIMEOUT_RESET;
    logic [SRC_COUNT-1:0] pend_src    = '0;
    logic [SRC_COUNT-1:0] seen_src    = '0;
    logic [31:0]          progress_at [SRC_COUNT];
    logic [31:0]          now_ms      = '0;
    logic [7:0]           period_cnt  = '0;
    logic                 ckpt_ok     = 1'b0;
    logic                 fail_latched = 1'b0;
    logic                 early_used  = 1'b0;
    logic                 last_ok     = 1'b0;

    logic [7:0] request_q [$];
    logic [7:0] verdict_q [$];

    bit   send_idle = 1'b0;
    bit   recv_idle = 1'b0;
    int   send_gap  = 0;
    int   recv_gap  = 0;
    int   errors    = 0;
    int   cycle_count = 0;
    bit   last_skipped = 1'b0;
    int   ticks_since_check = 0;
    logic [7:0] want;

    initial begin
        for (int s = 0; s < SRC_COUNT; s++) progress_at[s] = '0;
    end

    function automatic logic [7:0] pack_request(input req_type_t kind,
                                                input logic [SRC_IDX_W-1:0] src);
        return {1'b0, src, kind};
    endfunction

    // Apply one request to the mirror; return the result byte it produces
    function automatic logic [7:0] step_supervisor(input req_type_t kind,
                                                   input logic [SRC_IDX_W-1:0] src);
        logic        kick;
        logic        bad;
        logic        ok;
        logic [31:0] age;
        kick = 1'b0;
        bad  = 1'b0;
        case (kind)
            REQ_HEARTBEAT: begin
                if (src <= NUM_TASKS) pend_src[src] = 1'b1;
                else bad = 1'b1;
            end
            REQ_TICK: begin
                now_ms     = now_ms + 32'd1;
                period_cnt = period_cnt + 8'd1;
                if (period_cnt >= period_reg) begin
                    period_cnt = '0;
                    if (!fail_latched) begin
                        for (int s = 0; s < SRC_COUNT; s++) begin
                            if (pend_src[s]) begin
                                progress_at[s] = now_ms;
                                seen_src[s]    = 1'b1;
                            end
                        end
                        pend_src = '0;
                        ok = &seen_src;
                        for (int s = 0; s < SRC_COUNT; s++) begin
                            age = now_ms - progress_at[s];
                            if (age >= {16'd0, timeout_reg}) ok = 1'b0;
                        end
                        last_ok = ok;
                        if (ok) begin
                            ckpt_ok = 1'b1;
                            kick    = 1'b1;
                        end else if (now_ms >= {16'd0, timeout_reg}) begin
                            ckpt_ok      = 1'b0;
                            fail_latched = 1'b1;
                        end
                    end
                end
            end
            REQ_CHECKPOINT: begin
                kick = ckpt_ok && !fail_latched;
            end
            default: begin
                if (!early_used && !fail_latched) begin
                    early_used = 1'b1;
                    kick       = 1'b1;
                end
            end
        endcase
        return {3'b000, bad, last_ok, ckpt_ok, fail_latched, kick};
    endfunction

    // Request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                verdict_q.push_back(step_supervisor(req_type_t'(s_tdata[1:0]), s_tdata[6:2]));
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (send_idle && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 6);
                    s_tvalid <= 1'b0;
                end else if (request_q.size() != 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= request_q.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_bit(input string name, input logic exp_v, input logic act_v);
        if (act_v !== exp_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %b, got %b", $time, name, exp_v, act_v);
        end
    endtask

    // Result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing expected, expected none, got %h",
                             $time, m_tdata);
                end else begin
                    want = verdict_q.pop_front();
                    check_bit("refresh_kick", want[0], m_tdata[0]);
                    check_bit("failed", want[1], m_tdata[1]);
                    check_bit("checkpoint_allowed", want[2], m_tdata[2]);
                    check_bit("healthy", want[3], m_tdata[3]);
                    check_bit("bad_source", want[4], m_tdata[4]);
                    if (m_tdata[7:5] !== 3'b000) begin
                        errors++;
                        $display("%0t: tdata padding mismatch, expected 000, got %b",
                                 $time, m_tdata[7:5]);
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else if (recv_idle && $urandom_range(0, 7) == 0) begin
                recv_gap = $urandom_range(0, 6);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("%0t: no completion within %0d cycles", $time, CYCLE_CAP);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic wait_idle();
        while (request_q.size() != 0 || s_tvalid || verdict_q.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_CHECK_PERIOD) period_reg = value[7:0];
        else timeout_reg = value;
    endtask

    // One check window: heartbeats and noise spread over the ticks, with the
    // check-firing tick last so every heartbeat lands before the check
    task automatic queue_window(input bit may_skip);
        logic [7:0] items [$];
        logic [7:0] tmp;
        int         ticks;
        int         skip_src;
        int         j;
        ticks = (period_reg == 0 || ticks_since_check + 1 >= period_reg) ?
                1 : period_reg - ticks_since_check;
        skip_src = -1;
        if (may_skip && !last_skipped && $urandom_range(0, 3) == 0)
            skip_src = $urandom_range(0, NUM_TASKS);
        last_skipped = (skip_src >= 0);
        for (int t = 1; t < ticks; t++) items.push_back(pack_request(REQ_TICK, 5'd0));
        for (int s = 0; s < SRC_COUNT; s++)
            if (s != skip_src) items.push_back(pack_request(REQ_HEARTBEAT, s[4:0]));
        repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 3))
                0: items.push_back(pack_request(REQ_CHECKPOINT, 5'($urandom)));
                1: items.push_back(pack_request(REQ_EARLY, 5'($urandom)));
                2: items.push_back(pack_request(REQ_HEARTBEAT,
                                                5'($urandom_range(NUM_TASKS + 1, 31))));
                default: items.push_back(pack_request(REQ_HEARTBEAT,
                                                      5'($urandom_range(0, NUM_TASKS))));
            endcase
        end
        for (int i = items.size() - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = items[i];
            items[i] = items[j];
            items[j] = tmp;
        end
        foreach (items[i]) request_q.push_back(items[i]);
        request_q.push_back(pack_request(REQ_TICK, 5'($urandom)));
        ticks_since_check = 0;
    endtask

    task automatic run_phase(input logic [7:0] period, input logic [15:0] timeout,
                             input int windows, input bit idle);
        wait_idle();
        send_idle = idle;
        recv_idle = idle;
        write_reg(CFG_CHECK_PERIOD, {8'($urandom), period});
        write_reg(CFG_PROGRESS_TIMEOUT, timeout);
        ticks_since_check = period_cnt;
        repeat (windows)
            queue_window(timeout > ((period == 0) ? 16'd1 : {8'd0, period}));
    endtask

    initial begin
        logic [7:0] rand_period;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: early kick once, checkpoint refused, bad indexes, an
        // unhealthy check inside the startup grace, then a healthy one
        write_reg(CFG_CHECK_PERIOD, 16'd4);
        send_idle = 1'b1;
        recv_idle = 1'b1;
        request_q.push_back(pack_request(REQ_EARLY, 5'd0));
        request_q.push_back(pack_request(REQ_EARLY, 5'd31));
        request_q.push_back(pack_request(REQ_CHECKPOINT, 5'd0));
        request_q.push_back(pack_request(REQ_HEARTBEAT, 5'd0));
        request_q.push_back(pack_request(REQ_HEARTBEAT, 5'd1));
        request_q.push_back(pack_request(REQ_HEARTBEAT, 5'(NUM_TASKS + 1)));
        request_q.push_back(pack_request(REQ_HEARTBEAT, 5'd31));
        repeat (4) request_q.push_back(pack_request(REQ_TICK, 5'd0));
        request_q.push_back(pack_request(REQ_HEARTBEAT, 5'd2));
        request_q.push_back(pack_request(REQ_HEARTBEAT, 5'd3));
        request_q.push_back(pack_request(REQ_HEARTBEAT, 5'(NUM_TASKS)));
        repeat (4) request_q.push_back(pack_request(REQ_TICK, 5'd31));
        request_q.push_back(pack_request(REQ_CHECKPOINT, 5'd31));
        request_q.push_back(pack_request(REQ_EARLY, 5'd0));

        run_phase(8'd10, 16'd30, 12, 1'b1);
        run_phase(8'd1, 16'd1, 14, 1'b1);
        run_phase(8'd255, 16'd65535, 1, 1'b0);
        run_phase(8'd0, 16'd2, 15, 1'b1);
        rand_period = 8'($urandom_range(2, 12));
        run_phase(rand_period, {8'd0, rand_period} + 16'd1, 10, 1'b1);

        // Zero timeout: the first check latches failure; keep poking afterwards
        run_phase(8'($urandom_range(1, 8)), 16'd0, 3, 1'b0);
        repeat (40)
            request_q.push_back(pack_request(req_type_t'($urandom_range(0, 3)),
                                             5'($urandom)));
        wait_idle();
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
